/* rtl/scmc_pkg.sv */
// ----------------------------------------------------------------------------
// scmc_pkg: shared types and constants for the scanline motion corrector
// Codes and fixed widths, plus the command and status groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package scmc_pkg;

  // input item kinds
  localparam logic [1:0] ACT_FRAME = 2'd0;
  localparam logic [1:0] ACT_ROW   = 2'd1;
  localparam logic [1:0] ACT_PIXEL = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [1:0] REG_DEST_WIDTH = 2'd1;
  localparam logic [1:0] REG_DEST_HGT   = 2'd2;

  // fixed point format of the row positions
  localparam int FRAC_BITS = 8;
  localparam int POS_W     = 19;
  localparam int PIX_W     = 16;
  localparam int COORD_W   = 11;

  // controller -> datapath
  typedef struct packed {
    logic ready;   // input side may take an item
    logic horiz;   // horizontal interpolation, issue line buffer read
    logic wr;      // write line buffer, set up the row span
    logic mula;    // first product of the vertical blend
    logic mulb;    // second product, load divider
    logic div;     // one divider step
    logic emit;    // load output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pix_go;    // accepted item is a pixel within the row
    logic h_go;      // shifted pixel lands inside the destination
    logic span_go;   // at least one destination row to produce
    logic eq_y;      // rows coincide or are out of order: plain copy
    logic div_done;  // last divider step
    logic out_free;  // output register can take a result
    logic k_last;    // current row is the last of the span
  } sts_t;

endpackage

`default_nettype wire

/* rtl/scmc_ctrl.sv */
// ----------------------------------------------------------------------------
// scmc_ctrl: sequencer for the scanline motion corrector
// Steps each pixel through horizontal shift, line buffer access, and per
// destination row one blend and divide pass or, where rows coincide, a copy.
// ----------------------------------------------------------------------------
`default_nettype none

module scmc_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  input  wire scmc_pkg::sts_t sts,
  output scmc_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_HORIZ, S_READ, S_MULA, S_MULB, S_DIV, S_EMIT
  } state_t;

  state_t state;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid && sts.pix_go) state <= S_HORIZ;
        end
        S_HORIZ: begin
          state <= sts.h_go ? S_READ : S_IDLE;
        end
        S_READ: begin
          if (!sts.span_go) state <= S_IDLE;
          else state <= sts.eq_y ? S_EMIT : S_MULA;
        end
        S_MULA: state <= S_MULB;
        S_MULB: state <= S_DIV;
        S_DIV: begin
          if (sts.div_done) state <= S_EMIT;
        end
        S_EMIT: begin
          if (sts.out_free) begin
            if (sts.k_last) state <= S_IDLE;
            else state <= sts.eq_y ? S_EMIT : S_MULA;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // commands decoded from state
  always_comb begin
    cmd       = '0;
    cmd.ready = (state == S_IDLE);
    cmd.horiz = (state == S_HORIZ);
    cmd.wr    = (state == S_READ);
    cmd.mula  = (state == S_MULA);
    cmd.mulb  = (state == S_MULB);
    cmd.div   = (state == S_DIV);
    cmd.emit  = (state == S_EMIT) && sts.out_free;
  end

endmodule

`default_nettype wire

/* rtl/scmc_dp.sv */
// ----------------------------------------------------------------------------
// scmc_dp: datapath of the scanline motion corrector
// Row state, horizontal interpolation, line buffer, vertical blend with a
// bit-serial divider, configuration registers and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module scmc_dp #(
  parameter int MAX_SRC_WIDTH  = 1024,
  parameter int MAX_DEST_WIDTH = 2048,
  parameter int MAX_SPAN       = 4
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire scmc_pkg::cmd_t cmd,
  output scmc_pkg::sts_t      sts,
  input  wire               in_valid,
  input  wire  [1:0]        in_action,
  input  wire  [18:0]       in_x,
  input  wire  [18:0]       in_y,
  input  wire  [15:0]       in_pixel,
  input  wire               cfg_we,
  input  wire  [1:0]        cfg_index,
  input  wire  [11:0]       cfg_data,
  output logic              out_valid,
  input  wire               out_ready,
  output logic [10:0]       out_x,
  output logic [10:0]       out_y,
  output logic [15:0]       out_value,
  output logic              out_last,
  output logic              out_clipped
);

  localparam int AW   = (MAX_DEST_WIDTH > 1) ? $clog2(MAX_DEST_WIDTH) : 1;
  localparam int KW   = $clog2(MAX_SPAN + 1);
  localparam int FB   = scmc_pkg::FRAC_BITS;
  localparam int ONE  = 1 << FB;

  // configuration
  logic [10:0] src_w;
  logic [11:0] dst_w;
  logic [11:0] dst_h;

  // row state
  logic [18:0] prev_x, prev_y, cur_x, cur_y;
  logic [10:0] pix_idx;
  logic [15:0] prev_pix;
  logic        first_row, frame_open;

  // per item work registers
  logic [15:0] pix_r, v_r;
  logic [12:0] dx_r;
  logic [11:0] dy_r;
  logic [KW-1:0] k_r, n_r;
  logic        clipped_r;
  logic [18:0] num_r;
  logic [34:0] prod_a;
  logic [18:0] rem;
  logic [15:0] acc_lo;
  logic [15:0] quo;
  logic [3:0]  div_cnt;

  // line buffer
  logic [15:0] mem [MAX_DEST_WIDTH];
  logic [15:0] mem_q;

  logic        accept;
  assign accept = in_valid && cmd.ready;

  // saturated widths
  logic [10:0] w;
  logic [13:0] dw;
  assign w  = (13'(src_w) < 13'(MAX_SRC_WIDTH)) ? src_w : 11'(MAX_SRC_WIDTH);
  assign dw = (14'(dst_w) < 14'(MAX_DEST_WIDTH)) ? 14'(dst_w) : 14'(MAX_DEST_WIDTH);

  // horizontal shift
  logic [11:0] c_cur;
  logic [19:0] c_shift;
  logic [7:0]  q;
  logic        lead;
  logic [10:0] sx;
  logic [25:0] h_sum;
  logic [15:0] v_h;
  logic [12:0] dx_h;

  always_comb begin
    c_cur   = 12'((20'(cur_x) + 20'(ONE - 1)) >> FB);
    c_shift = 20'(c_cur) << FB;
    q       = 8'(c_shift - 20'(cur_x));
    lead    = (q != 8'd0) && (pix_idx == 11'd0);
    sx      = (q == 8'd0) ? pix_idx : pix_idx - 11'd1;
    h_sum   = 26'(9'(ONE) - 9'(q)) * 26'(prev_pix) + 26'(q) * 26'(pix_r) + 26'(ONE / 2);
    v_h     = (q == 8'd0) ? pix_r : h_sum[FB +: 16];
    dx_h    = 13'(c_cur) + 13'(sx);
  end

  // span of destination rows
  logic [11:0] cprev_x, dy1, dy2_raw, dy2;
  logic [11:0] hi_x;
  logic [11:0] n_full;
  logic        overlap;
  logic [18:0] den;

  always_comb begin
    cprev_x = 12'((20'(prev_x) + 20'(ONE - 1)) >> FB);
    hi_x    = 12'(prev_x >> FB) + 12'(w);
    overlap = (13'(dx_r) >= 13'(cprev_x)) && (13'(dx_r) < 13'(hi_x));
    dy1     = 12'((20'(prev_y) + 20'(ONE - 1)) >> FB);
    dy2_raw = 12'(cur_y >> FB) + 12'd1;
    dy2     = (dy2_raw > dst_h) ? dst_h : dy2_raw;
    n_full  = dy2 - dy1;
    den     = cur_y - prev_y;
  end

  // vertical weight, clamped to the denominator
  logic [20:0] num_w;
  logic [18:0] num_c;
  always_comb begin
    num_w = (21'(dy_r) << FB) - 21'(prev_y);
    num_c = (num_w > 21'(den)) ? den : num_w[18:0];
  end

  // blend sum and divider step
  logic [35:0] b_sum;
  logic [19:0] trial;
  always_comb begin
    b_sum = 36'(prod_a) + 36'(num_r) * 36'(v_r) + 36'(den >> 1);
    trial = {rem, acc_lo[15]};
  end

  // status
  always_comb begin
    sts.pix_go   = (in_action == scmc_pkg::ACT_PIXEL) && (pix_idx < w);
    sts.h_go     = !lead && (14'(dx_h) < dw);
    sts.span_go  = !first_row && overlap && (dy2 > dy1);
    sts.eq_y     = (cur_y <= prev_y);
    sts.div_done = (div_cnt == 4'd15);
    sts.out_free = !out_valid || out_ready;
    sts.k_last   = (k_r + KW'(1) == n_r);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      src_w <= 11'd1024;
      dst_w <= 12'd2048;
      dst_h <= 12'd2048;
    end else if (cfg_we) begin
      case (cfg_index)
        scmc_pkg::REG_SRC_WIDTH:  src_w <= cfg_data[10:0];
        scmc_pkg::REG_DEST_WIDTH: dst_w <= cfg_data;
        scmc_pkg::REG_DEST_HGT:   dst_h <= cfg_data;
        default: ;
      endcase
    end
  end

  // row state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x     <= '0;
      prev_y     <= '0;
      cur_x      <= '0;
      cur_y      <= '0;
      pix_idx    <= '0;
      prev_pix   <= '0;
      first_row  <= 1'b1;
      frame_open <= 1'b0;
    end else if (accept) begin
      if (in_action == scmc_pkg::ACT_FRAME ||
          (in_action == scmc_pkg::ACT_ROW && !frame_open)) begin
        cur_x      <= in_x;
        cur_y      <= in_y;
        pix_idx    <= '0;
        prev_pix   <= '0;
        first_row  <= 1'b1;
        frame_open <= 1'b1;
      end else if (in_action == scmc_pkg::ACT_ROW) begin
        prev_x    <= cur_x;
        prev_y    <= cur_y;
        cur_x     <= in_x;
        cur_y     <= in_y;
        pix_idx   <= '0;
        prev_pix  <= '0;
        first_row <= 1'b0;
      end
    end else if (cmd.horiz) begin
      pix_idx  <= pix_idx + 11'd1;
      prev_pix <= pix_r;
    end
  end

  // pixel capture and horizontal result
  always_ff @(posedge clk) begin
    if (accept) pix_r <= in_pixel;
    if (cmd.horiz) begin
      v_r  <= v_h;
      dx_r <= dx_h;
    end
  end

  // line buffer: read in the shift cycle, written in the cycle after
  always_ff @(posedge clk) begin
    if (cmd.horiz) mem_q <= mem[AW'(dx_h)];
    if (cmd.wr) mem[AW'(dx_r)] <= v_r;
  end

  // span setup and vertical blend
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      dy_r      <= dy1;
      k_r       <= '0;
      clipped_r <= (n_full > 12'(MAX_SPAN));
      n_r       <= (n_full > 12'(MAX_SPAN)) ? KW'(MAX_SPAN) : KW'(n_full);
    end else if (cmd.emit) begin
      dy_r <= dy_r + 12'd1;
      k_r  <= k_r + KW'(1);
    end
    if (cmd.mula) begin
      num_r  <= num_c;
      prod_a <= 35'(den - num_c) * 35'(mem_q);
    end
    if (cmd.mulb) begin
      rem     <= b_sum[34:16];
      acc_lo  <= b_sum[15:0];
      div_cnt <= '0;
    end else if (cmd.div) begin
      if (trial >= 20'(den)) begin
        rem <= 19'(trial - 20'(den));
        quo <= {quo[14:0], 1'b1};
      end else begin
        rem <= trial[18:0];
        quo <= {quo[14:0], 1'b0};
      end
      acc_lo  <= {acc_lo[14:0], 1'b0};
      div_cnt <= div_cnt + 4'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.emit) begin
      out_x       <= dx_r[10:0];
      out_y       <= dy_r[10:0];
      out_value   <= sts.eq_y ? v_r : quo;
      out_last    <= sts.k_last;
      out_clipped <= clipped_r;
    end
  end

endmodule

`default_nettype wire

/* rtl/scanline_motion_correction_linear_top.sv */
// ----------------------------------------------------------------------------
// scanline_motion_correction_linear_top: line-scan motion corrector
// Shifts each source row horizontally, keeps it in a line buffer and blends
// it against the previous row into the destination rows between them.
// ----------------------------------------------------------------------------
// Flow: one item is taken at a time. A row header, an ignored item or a pixel
// past the source width is only accepted. A pixel within the row that only
// primes the shift or lands outside the destination is accepted and shifted;
// otherwise it is accepted, shifted with a line buffer read and written to the
// line buffer, then per destination row passes the first and second multiply, a
// 16-step bit-serial divider and a load of the output register, or only the load
// where the rows coincide; at most MAX_SPAN rows per pixel. Results leave
// through one output register, so a stalled consumer holds the sequencer.
`default_nettype none

module scanline_motion_correction_linear_top #(
  parameter int MAX_SRC_WIDTH  = 1024,
  parameter int MAX_DEST_WIDTH = 2048,
  parameter int MAX_SPAN       = 4
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [55:0] s_tdata,   // x_position[18:0], y_position[37:19], pixel[53:38]
  input  wire  [1:0]  s_tuser,   // action
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [39:0] m_tdata,   // dest_x[10:0], dest_y[21:11], value[37:22]
  output logic        m_tlast,
  output logic        m_tuser,   // span_clipped
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_index,
  input  wire  [11:0] cfg_data
);

  scmc_pkg::cmd_t cmd;
  scmc_pkg::sts_t sts;
  logic [10:0] ox, oy;
  logic [15:0] oval;

  scmc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .sts      (sts),
    .cmd      (cmd)
  );

  scmc_dp #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_DEST_WIDTH (MAX_DEST_WIDTH),
    .MAX_SPAN       (MAX_SPAN)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .in_valid    (s_tvalid),
    .in_action   (s_tuser),
    .in_x        (s_tdata[18:0]),
    .in_y        (s_tdata[37:19]),
    .in_pixel    (s_tdata[53:38]),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_x       (ox),
    .out_y       (oy),
    .out_value   (oval),
    .out_last    (m_tlast),
    .out_clipped (m_tuser)
  );

  assign s_tready = cmd.ready;
  assign m_tdata  = {2'b00, oval, oy, ox};

endmodule

`default_nettype wire
